[sv/rpc_pkg.sv]
// Shared types and constants for the RC PWM pulse width capture block.
// Used by every module of the block but rpc_chan_ram; depends on nothing.
`default_nettype none

package rpc_pkg;

	localparam int CHAN_W     = 3;
	localparam int CAPT_W     = 32;
	localparam int WIDTH_W    = 15;
	localparam int WIN_W      = 10;
	localparam int MIRROR_W   = 17;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 15;

	// Result queue: holds every item that can be in flight behind the input.
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = 2;
	localparam int OUT_CNT_W = 3;

	localparam logic [WIDTH_W-1:0] WIDTH_MAX = 15'h7FFF;

	localparam logic [WIDTH_W-1:0] MIN_WIDTH_RST    = 15'd989;
	localparam logic [WIDTH_W-1:0] MID_WIDTH_RST    = 15'd1500;
	localparam logic [WIDTH_W-1:0] MAX_WIDTH_RST    = 15'd2013;
	localparam logic [WIN_W-1:0]   MATCH_WINDOW_RST = 10'd30;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_WIDTH    = 4'd0,
		CFG_MID_WIDTH    = 4'd1,
		CFG_MAX_WIDTH    = 4'd2,
		CFG_MATCH_WINDOW = 4'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [WIDTH_W-1:0] min_width;
		logic [WIDTH_W-1:0] mid_width;
		logic [WIDTH_W-1:0] max_width;
		logic [WIN_W-1:0]   match_window;
	} cfg_t;

	// Channel state after the update, handed from the update stage to evaluation.
	typedef struct packed {
		logic               valid;
		logic [CHAN_W-1:0]  chan;
		logic               done;
		logic [WIDTH_W-1:0] width;
		logic               next_falling;
	} upd_t;

	// One result beat, last field in the lowest bits.
	typedef struct packed {
		logic [MIRROR_W-1:0] mirrored_width;
		logic                near_max;
		logic                near_mid;
		logic                near_min;
		logic                next_falling;
		logic [WIDTH_W-1:0]  pulse_width;
		logic                pulse_done;
		logic [CHAN_W-1:0]   out_channel;
	} result_t;

endpackage

`default_nettype wire

[sv/rpc_chan_ram.sv]
// Per-channel state memory: one write port, one read port, registered read data.
// Stand-alone; no package use.
`default_nettype none

module rpc_chan_ram #(
	parameter int DEPTH = 6,
	parameter int AW    = 3,
	parameter int DW    = 47
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data_q,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

[sv/rpc_update.sv]
// Read-modify-write of per-channel capture state, with forwarding of the last write.
// Uses rpc_pkg and instantiates rpc_chan_ram.
`default_nettype none

module rpc_update #(
	parameter int NUM_CHANNELS = 6,
	parameter int COUNTER_BITS = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic [rpc_pkg::CHAN_W-1:0] in_chan,
	input  wire logic [COUNTER_BITS-1:0]    in_count,
	output rpc_pkg::upd_t                   upd_s2
);

	localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int WW = rpc_pkg::WIDTH_W;
	localparam int DW = COUNTER_BITS + WW;

	logic                       valid_s1;
	logic [rpc_pkg::CHAN_W-1:0] chan_s1;
	logic [COUNTER_BITS-1:0]    count_s1;

	logic [AW+rpc_pkg::CHAN_W-1:0] in_chan_wide;
	logic [AW+rpc_pkg::CHAN_W-1:0] chan_wide_s1;
	logic [AW-1:0]                 in_addr;
	logic [AW-1:0]                 addr_s1;

	logic [DW-1:0] rd_data;
	logic [DW-1:0] cur_entry;
	logic [DW-1:0] wr_data;

	logic          fwd_valid_q;
	logic [AW-1:0] fwd_addr_q;
	logic [DW-1:0] fwd_entry_q;

	logic [NUM_CHANNELS-1:0] awaiting_fall_q;
	logic [NUM_CHANNELS-1:0] width_valid_q;

	logic [COUNTER_BITS-1:0] cur_rise;
	logic [WW-1:0]           cur_width;
	logic [COUNTER_BITS-1:0] diff;
	logic [WW-1:0]           sat_width;
	logic [WW-1:0]           new_width;
	logic [COUNTER_BITS-1:0] new_rise;
	logic                    falling;

	assign in_chan_wide = (AW + rpc_pkg::CHAN_W)'(in_chan);
	assign chan_wide_s1 = (AW + rpc_pkg::CHAN_W)'(chan_s1);
	assign in_addr      = in_chan_wide[AW-1:0];
	assign addr_s1      = chan_wide_s1[AW-1:0];

	rpc_chan_ram #(
		.DEPTH(NUM_CHANNELS),
		.AW   (AW),
		.DW   (DW)
	) u_ram (
		.clk      (clk),
		.rd_en    (in_valid),
		.rd_addr  (in_addr),
		.rd_data_q(rd_data),
		.wr_en    (valid_s1),
		.wr_addr  (addr_s1),
		.wr_data  (wr_data)
	);

	// The read for this item was issued on the same edge as the previous write.
	always_comb begin
		cur_entry = rd_data;
		if (fwd_valid_q && fwd_addr_q == addr_s1) begin
			cur_entry = fwd_entry_q;
		end
	end

	assign cur_rise  = cur_entry[DW-1:WW];
	assign cur_width = width_valid_q[addr_s1] ? cur_entry[WW-1:0] : '0;
	assign falling   = awaiting_fall_q[addr_s1];

	assign diff      = count_s1 - cur_rise;
	assign sat_width = (|diff[COUNTER_BITS-1:WW]) ? rpc_pkg::WIDTH_MAX : diff[WW-1:0];

	// Keep the old width when the counter wrapped or did not advance between the edges.
	assign new_width = (falling && count_s1 > cur_rise) ? sat_width : cur_width;
	assign new_rise  = falling ? cur_rise : count_s1;
	assign wr_data   = {new_rise, new_width};

	always_ff @(posedge clk) begin
		if (in_valid) begin
			chan_s1  <= in_chan;
			count_s1 <= in_count;
		end
		fwd_addr_q      <= addr_s1;
		fwd_entry_q     <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1        <= 1'b0;
			fwd_valid_q     <= 1'b0;
			awaiting_fall_q <= '0;
			width_valid_q   <= '0;
			upd_s2          <= '0;
		end else begin
			valid_s1            <= in_valid;
			fwd_valid_q         <= valid_s1;
			upd_s2.valid        <= valid_s1;
			upd_s2.chan         <= chan_s1;
			upd_s2.done         <= falling;
			upd_s2.width        <= new_width;
			upd_s2.next_falling <= ~falling;
			if (valid_s1) begin
				awaiting_fall_q[addr_s1] <= ~falling;
				width_valid_q[addr_s1]   <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[sv/rpc_eval.sv]
// Match flags and mirrored width for one updated channel.
// Uses rpc_pkg types.
`default_nettype none

module rpc_eval (
	input  wire rpc_pkg::cfg_t cfg,
	input  wire rpc_pkg::upd_t upd,
	output rpc_pkg::result_t   res
);

	localparam int MW = rpc_pkg::MIRROR_W;

	logic signed [MW-1:0] w_s;
	logic signed [MW-1:0] h_s;
	logic signed [MW-1:0] min_s;
	logic signed [MW-1:0] mid_s;
	logic signed [MW-1:0] max_s;

	assign w_s   = signed'(MW'(upd.width));
	assign h_s   = signed'(MW'(cfg.match_window));
	assign min_s = signed'(MW'(cfg.min_width));
	assign mid_s = signed'(MW'(cfg.mid_width));
	assign max_s = signed'(MW'(cfg.max_width));

	always_comb begin
		res.out_channel    = upd.chan;
		res.pulse_done     = upd.done;
		res.pulse_width    = upd.width;
		res.next_falling   = upd.next_falling;
		// Open window: strictly between ref - window and ref + window.
		res.near_min       = (w_s > min_s - h_s) && (w_s < min_s + h_s);
		res.near_mid       = (w_s > mid_s - h_s) && (w_s < mid_s + h_s);
		res.near_max       = (w_s > max_s - h_s) && (w_s < max_s + h_s);
		res.mirrored_width = MW'({1'b0, cfg.mid_width, 1'b0}) - MW'(upd.width);
	end

endmodule

`default_nettype wire

[sv/rpc_out_fifo.sv]
// Result queue between the update pipeline and the output channel.
// Uses rpc_pkg for the result type and depth constants.
`default_nettype none

module rpc_out_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire rpc_pkg::result_t push_data,
	input  wire logic             pop,
	output rpc_pkg::result_t      head,
	output logic                  not_empty
);

	rpc_pkg::result_t                 slot_q [rpc_pkg::OUT_DEPTH];
	logic [rpc_pkg::OUT_PTR_W-1:0]    wr_ptr_q;
	logic [rpc_pkg::OUT_PTR_W-1:0]    rd_ptr_q;
	logic [rpc_pkg::OUT_CNT_W-1:0]    cnt_q;
	logic                             do_pop;

	assign not_empty = (cnt_q != '0);
	assign head      = slot_q[rd_ptr_q];
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[sv/rc_pwm_pulse_width_capture.sv]
// Top level of the multi-channel RC PWM pulse width capture block.
// Uses rpc_pkg; instantiates rpc_update, rpc_eval and rpc_out_fifo.
//
//   channel   direction  beat contents (low bit first)
//   s_*       in         channel[2:0], capture_value[34:3]
//   m_*       out        tdata: out_channel, pulse_width, next_falling,
//                        near_min, near_mid, near_max, mirrored_width;
//                        tuser: pulse_done
//   cfg_*     in         write of min_width, mid_width, max_width, match_window
//
// One capture event per cycle, sustained while m_* takes results. A result is
// offered on m_* once its event has gone through the pipeline: the state
// memory read feeds the read-modify-write stage, then the match evaluation
// writes the result queue. Back-to-back events on the same channel are served
// by forwarding the last write. Reset clears the edge phase and width of every
// channel at once; no clearing pass. Stalls on m_* fill the four-entry result
// queue; s_tready drops once four events are in flight.
// Events for channels at or above NUM_CHANNELS are taken and dropped.
`default_nettype none

module rc_pwm_pulse_width_capture #(
	parameter int NUM_CHANNELS = 6,
	parameter int COUNTER_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,    // channel[2:0], capture_value[34:3]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata,    // out_channel[2:0], pulse_width[17:3],
	                                     // next_falling[18], near_min[19], near_mid[20],
	                                     // near_max[21], mirrored_width[38:22]
	output logic             m_tuser,    // pulse_done
	input  wire logic        cfg_wen,
	input  wire logic [3:0]  cfg_index,
	input  wire logic [14:0] cfg_data
);

	localparam int CW = rpc_pkg::CHAN_W;

	rpc_pkg::cfg_t    cfg_q;
	rpc_pkg::upd_t    upd_s2;
	rpc_pkg::result_t res;
	rpc_pkg::result_t head;

	logic [CW-1:0]                 in_chan;
	logic [rpc_pkg::CAPT_W-1:0]    in_capt;
	logic [CW+4:0]                 in_chan_wide;
	logic                          in_range;
	logic                          take;
	logic                          give;
	logic [rpc_pkg::OUT_CNT_W-1:0] inflight_q;

	// Unpack the input beat; keep only the counter's live bits.
	assign in_chan      = s_tdata[CW-1:0];
	assign in_capt      = s_tdata[CW+rpc_pkg::CAPT_W-1:CW];
	assign in_chan_wide = (CW + 5)'(in_chan);
	assign in_range     = in_chan_wide < (CW + 5)'(NUM_CHANNELS);

	// Admit a beat only while the result queue can absorb everything in flight.
	assign s_tready = (inflight_q < rpc_pkg::OUT_CNT_W'(rpc_pkg::OUT_DEPTH));
	assign take     = s_tvalid && s_tready && in_range;
	assign give     = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			case ({take, give})
				2'b10:   inflight_q <= inflight_q + 1'b1;
				2'b01:   inflight_q <= inflight_q - 1'b1;
				default: inflight_q <= inflight_q;
			endcase
		end
	end

	// Configuration registers; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_width    <= rpc_pkg::MIN_WIDTH_RST;
			cfg_q.mid_width    <= rpc_pkg::MID_WIDTH_RST;
			cfg_q.max_width    <= rpc_pkg::MAX_WIDTH_RST;
			cfg_q.match_window <= rpc_pkg::MATCH_WINDOW_RST;
		end else if (cfg_wen) begin
			unique case (rpc_pkg::cfg_idx_t'(cfg_index))
				rpc_pkg::CFG_MIN_WIDTH:    cfg_q.min_width    <= cfg_data;
				rpc_pkg::CFG_MID_WIDTH:    cfg_q.mid_width    <= cfg_data;
				rpc_pkg::CFG_MAX_WIDTH:    cfg_q.max_width    <= cfg_data;
				rpc_pkg::CFG_MATCH_WINDOW: cfg_q.match_window <= cfg_data[rpc_pkg::WIN_W-1:0];
				default: ;
			endcase
		end
	end

	rpc_update #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.COUNTER_BITS(COUNTER_BITS)
	) u_update (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(take),
		.in_chan (in_chan),
		.in_count(in_capt[COUNTER_BITS-1:0]),
		.upd_s2  (upd_s2)
	);

	rpc_eval u_eval (
		.cfg(cfg_q),
		.upd(upd_s2),
		.res(res)
	);

	rpc_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (upd_s2.valid),
		.push_data(res),
		.pop      (m_tready),
		.head     (head),
		.not_empty(m_tvalid)
	);

	// Pulse completion travels as tuser; the rest packs into tdata.
	assign m_tuser = head.pulse_done;
	assign m_tdata = {1'b0, head.mirrored_width, head.near_max, head.near_mid,
		head.near_min, head.next_falling, head.pulse_width, head.out_channel};

endmodule

`default_nettype wire

[test/rc_pwm_pulse_width_capture_chk.sv]
// Scoreboard for the RC PWM pulse width capture block: tracks per-channel edge
// state, predicts every result beat and compares it field by field.
// Depends on rpc_pkg for field widths and register indexes.
`timescale 1ns / 100ps

module rc_pwm_pulse_width_capture_chk #(
	parameter int NUM_CHANNELS = 6,
	parameter int COUNTER_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,    // channel[2:0], capture_value[34:3]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,    // out_channel, pulse_width, next_falling,
	                                // near_min, near_mid, near_max, mirrored_width
	input  logic        m_tuser,    // pulse_done
	input  logic        cfg_wen,
	input  logic [3:0]  cfg_index,
	input  logic [14:0] cfg_data,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [rpc_pkg::CHAN_W-1:0]   chan;
		logic                         done;
		logic [rpc_pkg::WIDTH_W-1:0]  width;
		logic                         next_fall;
		logic                         near_min;
		logic                         near_mid;
		logic                         near_max;
		logic [rpc_pkg::MIRROR_W-1:0] mirror;
	} capture_result_t;

	capture_result_t expected_q[$];
	int errors;

	logic [rpc_pkg::WIDTH_W-1:0] min_w, mid_w, max_w;
	logic [rpc_pkg::WIN_W-1:0]   win;

	logic                        armed_fall [NUM_CHANNELS];
	logic [31:0]                 rise_at    [NUM_CHANNELS];
	logic [rpc_pkg::WIDTH_W-1:0] width_st   [NUM_CHANNELS];

	// Open window test, done in signed integers so nothing wraps.
	function automatic logic near_ref(input logic [14:0] w, input logic [14:0] r);
		int wi, ri, hi;
		wi = int'(w);
		ri = int'(r);
		hi = int'(win);
		return (wi > ri - hi) && (wi < ri + hi);
	endfunction

	task automatic apply_capture(input logic [2:0] ch, input logic [31:0] raw);
		capture_result_t res;
		logic [63:0] cnt;
		logic [63:0] span;
		int mirror_i;
		cnt = {32'd0, raw} & ((64'd1 << COUNTER_BITS) - 64'd1);
		// drop events for channels that do not exist
		if (int'(ch) >= NUM_CHANNELS)
			return;
		res.done = 1'b0;
		if (!armed_fall[ch]) begin
			rise_at[ch] = cnt[31:0];
			armed_fall[ch] = 1'b1;
		end else begin
			// keep the old width when the counter wrapped or did not advance
			if (cnt[31:0] > rise_at[ch]) begin
				span = cnt - {32'd0, rise_at[ch]};
				width_st[ch] = (span > 64'd32767) ? rpc_pkg::WIDTH_MAX : span[14:0];
			end
			armed_fall[ch] = 1'b0;
			res.done = 1'b1;
		end
		mirror_i = 2 * int'(mid_w) - int'(width_st[ch]);
		res.chan      = ch;
		res.width     = width_st[ch];
		res.next_fall = armed_fall[ch];
		res.near_min  = near_ref(width_st[ch], min_w);
		res.near_mid  = near_ref(width_st[ch], mid_w);
		res.near_max  = near_ref(width_st[ch], max_w);
		res.mirror    = mirror_i[16:0];
		expected_q.push_back(res);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endtask

	task automatic check_result();
		capture_result_t want;
		if (expected_q.size() == 0) begin
			$error("result beat with no capture event waiting: tdata 0x%0h", m_tdata);
			errors++;
			return;
		end
		want = expected_q.pop_front();
		check_field("out_channel",    32'(want.chan),      32'(m_tdata[2:0]));
		check_field("pulse_done",     32'(want.done),      32'(m_tuser));
		check_field("pulse_width",    32'(want.width),     32'(m_tdata[17:3]));
		check_field("next_falling",   32'(want.next_fall), 32'(m_tdata[18]));
		check_field("near_min",       32'(want.near_min),  32'(m_tdata[19]));
		check_field("near_mid",       32'(want.near_mid),  32'(m_tdata[20]));
		check_field("near_max",       32'(want.near_max),  32'(m_tdata[21]));
		check_field("mirrored_width", 32'(want.mirror),    32'(m_tdata[38:22]));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_w = rpc_pkg::MIN_WIDTH_RST;
			mid_w = rpc_pkg::MID_WIDTH_RST;
			max_w = rpc_pkg::MAX_WIDTH_RST;
			win   = rpc_pkg::MATCH_WINDOW_RST;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				armed_fall[i] = 1'b0;
				rise_at[i]    = 32'd0;
				width_st[i]   = '0;
			end
			expected_q.delete();
			errors = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result();
			if (cfg_wen) begin
				case (cfg_index)
					rpc_pkg::CFG_MIN_WIDTH:    min_w = cfg_data;
					rpc_pkg::CFG_MID_WIDTH:    mid_w = cfg_data;
					rpc_pkg::CFG_MAX_WIDTH:    max_w = cfg_data;
					rpc_pkg::CFG_MATCH_WINDOW: win   = cfg_data[9:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				apply_capture(s_tdata[2:0], s_tdata[34:3]);
			pending <= expected_q.size();
			fail_count <= errors;
		end
	end

endmodule

[test/rc_pwm_pulse_width_capture_tb.sv]
// Top of the RC PWM pulse width capture testbench: clock, reset, capture event
// stimulus, result back-pressure, register programming and the verdict.
// Depends on rpc_pkg, rc_pwm_pulse_width_capture and rc_pwm_pulse_width_capture_chk.
`timescale 1ns / 100ps

module rc_pwm_pulse_width_capture_tb;

	localparam int NUM_CH         = 6;
	localparam int HOLD_OFF_BEATS = 150;   // long receiver hold-off, in cycles
	localparam int DRAIN_CYCLES   = 6;     // pipeline depth plus margin
	localparam int IDLE_LIMIT     = 2000;  // cycles with no beat before giving up

	// Index outside the register list: the block must ignore the write.
	localparam logic [3:0] CFG_SPARE_IDX = 4'd12;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata   = '0;    // channel[2:0], capture_value[34:3]
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [39:0] m_tdata;           // out_channel, pulse_width, next_falling,
	                                // near_min, near_mid, near_max, mirrored_width
	logic        m_tuser;           // pulse_done
	logic        cfg_wen   = 1'b0;
	logic [3:0]  cfg_index = '0;
	logic [14:0] cfg_data  = '0;

	int fail_count;
	int pending;
	int idle_cycles = 0;

	// Stimulus-side view of each channel, used only to shape well-formed pulses.
	logic        armed_fall [NUM_CH];
	logic [31:0] sent_rise  [NUM_CH];
	int          cur_min, cur_mid, cur_max, cur_win;

	// Traffic shaping flags for the sender and the receiver.
	logic tx_eager     = 1'b0;
	logic rx_eager     = 1'b0;
	logic hold_off_req = 1'b0;

	rc_pwm_pulse_width_capture #(
		.NUM_CHANNELS(NUM_CH),
		.COUNTER_BITS(32)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	rc_pwm_pulse_width_capture_chk #(
		.NUM_CHANNELS(NUM_CH),
		.COUNTER_BITS(32)
	) chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	// 4 ns clock: two ns high, two ns low.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog: end the run when no beat moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// Mostly short gaps, now and then a long one; none at all in eager stretches.
	function automatic int pick_gap(input logic eager);
		int r;
		r = $urandom_range(0, 99);
		if (eager || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Receiver: drive m_tready at each falling edge, one assignment per step.
	// A hold-off request holds tready low for a long, self-counted stretch.
	initial begin
		int stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_left = HOLD_OFF_BEATS - 1;
				m_tready <= 1'b0;
			end else if (!rx_eager && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap(1'b0);
				if (stall_left == 0)
					stall_left = 1;
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Send one capture event. Call at a falling edge; return at a falling edge.
	// Keep tvalid high into the next call when no gap follows.
	task automatic post_capture(input logic [2:0] ch, input logic [31:0] cap);
		int gap;
		if (int'(ch) < NUM_CH) begin
			if (!armed_fall[ch])
				sent_rise[ch] = cap;
			armed_fall[ch] = !armed_fall[ch];
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, cap, ch};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
		gap = pick_gap(tx_eager);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Drop tvalid, wait for every outstanding result, then idle for
	// a drain margin.
	task automatic settle();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Write the three limits and the window, then a write to an unused index that must be ignored.
	task automatic program_regs(input logic [14:0] mn, input logic [14:0] md,
	                            input logic [14:0] mx, input logic [14:0] wn);
		cfg_wen   <= 1'b1;
		cfg_index <= rpc_pkg::CFG_MIN_WIDTH;
		cfg_data  <= mn;
		@(negedge clk);
		cfg_index <= rpc_pkg::CFG_MID_WIDTH;
		cfg_data  <= md;
		@(negedge clk);
		cfg_index <= rpc_pkg::CFG_MAX_WIDTH;
		cfg_data  <= mx;
		@(negedge clk);
		cfg_index <= rpc_pkg::CFG_MATCH_WINDOW;
		cfg_data  <= wn;
		@(negedge clk);
		cfg_index <= CFG_SPARE_IDX;
		cfg_data  <= 15'h7FFF;
		@(negedge clk);
		cfg_wen <= 1'b0;
		cur_min = int'(mn);
		cur_mid = int'(md);
		cur_max = int'(mx);
		cur_win = int'(wn[9:0]);
	endtask

	// Random traffic: mostly rise/fall pairs whose widths land around the
	// current limits, plus wrapped, equal and oversized pulses, out-of-order
	// noise, and events on channels that do not exist (not counted).
	task automatic run_random(input int n);
		int done_cnt, kind, sel, ref_w, span, w;
		logic [2:0]  ch;
		logic [31:0] cap;
		done_cnt = 0;
		while (done_cnt < n) begin
			kind = $urandom_range(0, 19);
			if (kind < 16) begin
				ch = 3'($urandom_range(0, NUM_CH - 1));
				if (!armed_fall[ch]) begin
					cap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5000) : $urandom();
				end else begin
					sel = $urandom_range(0, 9);
					if (sel <= 5) begin
						case ($urandom_range(0, 2))
							0:       ref_w = cur_min;
							1:       ref_w = cur_mid;
							default: ref_w = cur_max;
						endcase
						span = cur_win + 2;
						w = ref_w + int'($urandom_range(0, 2 * span)) - span;
						if (w < 1)
							w = 1;
						cap = sent_rise[ch] + 32'(w);
					end else if (sel == 6) begin
						cap = sent_rise[ch] + $urandom_range(1, 4000);
					end else if (sel == 7) begin
						cap = sent_rise[ch] + $urandom_range(32000, 200000);
					end else if (sel == 8) begin
						cap = sent_rise[ch];
					end else begin
						cap = sent_rise[ch] - $urandom_range(1, 5000);
					end
				end
				done_cnt++;
			end else if (kind < 19) begin
				ch = 3'($urandom_range(0, NUM_CH - 1));
				cap = $urandom();
				done_cnt++;
			end else begin
				ch = 3'($urandom_range(NUM_CH, 7));
				cap = $urandom();
			end
			post_capture(ch, cap);
		end
	endtask

	initial begin
		for (int i = 0; i < NUM_CH; i++) begin
			armed_fall[i] = 1'b0;
			sent_rise[i]  = 32'd0;
		end
		cur_min = int'(rpc_pkg::MIN_WIDTH_RST);
		cur_mid = int'(rpc_pkg::MID_WIDTH_RST);
		cur_max = int'(rpc_pkg::MAX_WIDTH_RST);
		cur_win = int'(rpc_pkg::MATCH_WINDOW_RST);

		// Hold reset, then release it between edges.
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed pulses with the reset limits.
		post_capture(3'd0, 32'd0);              // centre stick
		post_capture(3'd0, 32'd1500);
		post_capture(3'd5, 32'd100);            // stick minimum, top channel
		post_capture(3'd5, 32'd1089);
		post_capture(3'd1, 32'd10);             // just inside the max window
		post_capture(3'd1, 32'd2052);
		post_capture(3'd1, 32'd10);             // on the window edge, outside
		post_capture(3'd1, 32'd2053);
		post_capture(3'd6, 32'hFFFF_FFFF);      // channels that do not exist
		post_capture(3'd7, 32'd0);
		post_capture(3'd2, 32'hFFFF_FFFF);      // counter wrap: keep old width
		post_capture(3'd2, 32'd0);
		post_capture(3'd2, 32'd0);              // widest pulse: saturate
		post_capture(3'd2, 32'hFFFF_FFFF);
		post_capture(3'd3, 32'd5000);           // equal counts: keep old width
		post_capture(3'd3, 32'd5000);
		post_capture(3'd4, 32'hFFFF_0000);      // exactly the largest width
		post_capture(3'd4, 32'hFFFF_7FFF);
		post_capture(3'd4, 32'd0);              // one past it
		post_capture(3'd4, 32'd32768);
		post_capture(3'd3, 32'd7);              // one-tick pulse
		post_capture(3'd3, 32'd8);

		// Typical limits with random idling on both sides.
		settle();
		program_regs(15'd1000, 15'd1520, 15'd2040, 15'd50);
		run_random(250);

		// All limits and the window at zero: no match, negative mirror.
		settle();
		program_regs(15'd0, 15'd0, 15'd0, 15'd0);
		run_random(150);

		// All limits at the top, window data with bits above its width.
		// Hold the receiver off while the sender floods the block.
		settle();
		program_regs(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF);
		tx_eager = 1'b1;
		hold_off_req = 1'b1;
		run_random(150);
		tx_eager = 1'b0;

		// Random typical limits, full rate with no idling.
		settle();
		program_regs(15'($urandom_range(800, 1200)), 15'($urandom_range(1300, 1700)),
		             15'($urandom_range(1800, 2200)), 15'($urandom_range(0, 1023)));
		tx_eager = 1'b1;
		rx_eager = 1'b1;
		run_random(200);
		tx_eager = 1'b0;
		rx_eager = 1'b0;

		// Fully random limits, random idling and one more long hold-off.
		settle();
		program_regs(15'($urandom()), 15'($urandom()), 15'($urandom()), 15'($urandom()));
		hold_off_req = 1'b1;
		run_random(250);

		settle();
		if (fail_count == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[files.f]
sv/rpc_pkg.sv
sv/rpc_chan_ram.sv
sv/rpc_update.sv
sv/rpc_eval.sv
sv/rpc_out_fifo.sv
sv/rc_pwm_pulse_width_capture.sv
test/rc_pwm_pulse_width_capture_chk.sv
test/rc_pwm_pulse_width_capture_tb.sv
